FILE: sv/gfau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, operation codes and GF(2^8) helper functions (polynomial 0x11B).
// ----------------------------------------------------------------------------
package gfau_pkg;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_XTIME = 2'd1;
   localparam logic [1:0] FUNC_MUL   = 2'd2;
   localparam logic [1:0] FUNC_DIV   = 2'd3;

   localparam int unsigned GF_BITS   = 8;
   localparam logic [7:0]  GF_REDUCE = 8'h1B;

   // Six square-and-multiply cells build b^127, the last cell forms a * (b^127)^2.
   localparam int unsigned NUM_CELLS = GF_BITS - 1;

   typedef struct packed {
      logic       valid;
      logic [1:0] func;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [7:0] acc;
      logic [7:0] imm;
   } stage_type;

   function automatic logic [7:0] gf_xtime(input logic [7:0] v);
      logic [7:0] r;
      r = {v[6:0], 1'b0};
      if (v[7]) begin
         r = r ^ GF_REDUCE;
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] term;
      acc  = 8'h00;
      term = a;
      for (int k = 0; k < GF_BITS; k++) begin
         if (b[k]) begin
            acc = acc ^ term;
         end
         term = gf_xtime(term);
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

FILE: sv/gfau_entry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfau_entry
// Front of the cell chain: forms the one-step results and seeds the chain.
// ----------------------------------------------------------------------------
module gfau_entry
   import gfau_pkg::*;
(
   input  wire logic       accept,
   input  wire logic [1:0] func,
   input  wire logic [7:0] operand_a,
   input  wire logic [7:0] operand_b,
   output stage_type       stage_out
);

   logic [7:0] imm;

   always_comb begin
      unique case (func) inside
         FUNC_ADD:           imm = operand_a ^ operand_b;
         FUNC_XTIME:         imm = gf_xtime(operand_a);
         FUNC_MUL, FUNC_DIV: imm = gf_mul(operand_a, operand_b);
      endcase
   end

   // Seed the accumulator with the divisor itself.
   assign stage_out.valid     = accept;
   assign stage_out.func      = func;
   assign stage_out.operand_a = operand_a;
   assign stage_out.operand_b = operand_b;
   assign stage_out.acc       = operand_b;
   assign stage_out.imm       = imm;

endmodule
`default_nettype wire

FILE: sv/gfau_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfau_cell
// One square-and-multiply cell: acc <= acc^2 * mult, rest of the item advances.
// ----------------------------------------------------------------------------
module gfau_cell
   import gfau_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire stage_type  stage_in,
   input  wire logic [7:0] mult_in,
   output stage_type       stage_out
);

   stage_type  stage_ff;
   stage_type  stage_next_in;
   logic [7:0] square;

   always_comb begin
      square             = gf_mul(stage_in.acc, stage_in.acc);
      stage_next_in      = stage_in;
      stage_next_in.acc  = gf_mul(square, mult_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

FILE: sv/gf256_arithmetic_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_core
// GF(2^8) add, multiply by x, multiply and divide over a chain of cells.
// ----------------------------------------------------------------------------
//  channel   ports                                         flow
//  request   start, busy, req_func, req_operand_a/b        in, start && !busy
//  response  rsp_valid, rsp_field_result                   out, one-cycle strobe
//
//  One transfer per cycle; busy stays low.
//  Every operation passes through the seven square-and-multiply cells that the
//  divide runs through (b^254 then times a).
//  Reset clears the valid bits of the chain; items in flight are dropped.
//  The receiver cannot stall, so the chain advances every cycle.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_core
   import gfau_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_operand_a,
   input  wire logic [7:0] req_operand_b,
   output logic            rsp_valid,
   output logic [7:0]      rsp_field_result
);

   stage_type  chain [NUM_CELLS+1];
   logic [7:0] mult  [NUM_CELLS];

   assign busy = 1'b0;

   gfau_entry u_entry (
      .accept    (start && !busy),
      .func      (req_func),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .stage_out (chain[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      // The last cell multiplies by the dividend, the others by the divisor.
      if (k == NUM_CELLS - 1) begin : g_last
         assign mult[k] = chain[k].operand_a;
      end else begin : g_mid
         assign mult[k] = chain[k].operand_b;
      end

      gfau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[k]),
         .mult_in   (mult[k]),
         .stage_out (chain[k+1])
      );
   end

   assign rsp_valid        = chain[NUM_CELLS].valid;
   assign rsp_field_result = (chain[NUM_CELLS].func == FUNC_DIV) ? chain[NUM_CELLS].acc
                                                                 : chain[NUM_CELLS].imm;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("request transfer without response after seven cycles");

   a_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && chain[NUM_CELLS].func == FUNC_ADD) |->
         (rsp_field_result == (chain[NUM_CELLS].operand_a ^ chain[NUM_CELLS].operand_b)))
      else $error("add result is not the xor of the operands");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && chain[NUM_CELLS].func == FUNC_DIV && chain[NUM_CELLS].operand_b == 8'h00)
         |-> (rsp_field_result == 8'h00))
      else $error("divide by zero does not give zero");

   a_div_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && chain[NUM_CELLS].func == FUNC_DIV && chain[NUM_CELLS].operand_b == 8'h01)
         |-> (rsp_field_result == chain[NUM_CELLS].operand_a))
      else $error("divide by one does not return the dividend");

endmodule
`default_nettype wire

FILE: tb/sv/gf256_arithmetic_unit_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit_core_test
// Self-checking bench for the GF(2^8) unit: drives add, multiply by x,
// multiply and divide requests with random gaps, predicts each byte with an
// independent carry-less multiply / exponentiation model and checks every
// response strobe in order.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit_core_test;
   import gfau_pkg::*;

   localparam int unsigned CLOCK_HALF   = 6;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned SETTLE       = 12;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned PHASE_ITEMS  = 150;
   localparam logic [8:0]  FIELD_POLY   = {1'b1, GF_REDUCE};

   // Field arithmetic used for prediction.
   function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
      logic [14:0] wide;
      wide = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            wide = wide ^ (15'(a) << i);
         end
      end
      // fold the high terms back through the field polynomial
      for (int k = 14; k >= 8; k--) begin
         if (wide[k]) begin
            wide = wide ^ (15'(FIELD_POLY) << (k - 8));
         end
      end
      return wide[7:0];
   endfunction

   function automatic logic [7:0] field_power(input logic [7:0] base, input logic [7:0] expo);
      logic [7:0] acc;
      logic [7:0] sq;
      acc = 8'h01;
      sq  = base;
      for (int i = 0; i < 8; i++) begin
         if (expo[i]) begin
            acc = field_product(acc, sq);
         end
         sq = field_product(sq, sq);
      end
      return acc;
   endfunction

   function automatic logic [7:0] field_result_of(input logic [1:0] func,
                                                  input logic [7:0] a, input logic [7:0] b);
      case (func)
         FUNC_ADD:   return a ^ b;
         FUNC_XTIME: return field_product(a, 8'h02);
         FUNC_MUL:   return field_product(a, b);
         default:    return field_product(a, field_power(b, 8'd254));
      endcase
   endfunction

   class field_scoreboard;
      logic [7:0] expected_q[$];
      int         errors;
      int         checked;
      int         op_count[4];

      function void note_request(input logic [1:0] func, input logic [7:0] a,
                                 input logic [7:0] b);
         expected_q.push_back(field_result_of(func, a, b));
         op_count[func]++;
      endfunction

      function void check_result(input logic [7:0] got);
         logic [7:0] want;
         if (expected_q.size() == 0) begin
            $error("field_result: unexpected response, actual %02h", got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (got !== want) begin
               $error("field_result: expected %02h, actual %02h", want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_func = FUNC_ADD;
   logic [7:0] req_operand_a = 8'h00;
   logic [7:0] req_operand_b = 8'h00;
   logic       busy;
   logic       rsp_valid;
   logic [7:0] rsp_field_result;

   field_scoreboard sb = new();
   int              idle_pct = 0;
   int              quiet_cycles = 0;

   gf256_arithmetic_unit_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_field_result(rsp_field_result)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Monitor transfers on both channels and guard against a hang.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) begin
            sb.note_request(req_func, req_operand_a, req_operand_b);
         end
         if (rsp_valid) begin
            sb.check_result(rsp_field_result);
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("gf256_arithmetic_unit_core_test failed");
            $finish;
         end
      end
   end

   // Present one request; return at the edge that takes it.
   task automatic send_request(input logic [1:0] func, input logic [7:0] a,
                               input logic [7:0] b);
      logic taken;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_operand_a <= a;
      req_operand_b <= b;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Hold off until every outstanding response has come back.
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Mostly random bytes, with the corner values mixed in often.
   function automatic logic [7:0] pick_operand();
      case ($urandom_range(0, 11))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h80;
         3:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [7:0] edge_vals[4];
      edge_vals = '{8'h00, 8'h01, 8'h80, 8'hFF};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: corners of every operation, divide by zero, ignored operand_b
      foreach (edge_vals[i]) begin
         send_request(FUNC_ADD, edge_vals[i], edge_vals[3 - i]);
         send_request(FUNC_MUL, edge_vals[i], edge_vals[(i + 2) % 4]);
         send_request(FUNC_DIV, edge_vals[(i + 1) % 4], edge_vals[i]);
      end
      send_request(FUNC_XTIME, 8'h80, 8'hFF);
      send_request(FUNC_XTIME, 8'hFF, 8'h00);
      send_request(FUNC_XTIME, 8'h7F, 8'($urandom_range(0, 255)));
      send_request(FUNC_XTIME, 8'h00, 8'hA5);
      send_request(FUNC_MUL, 8'h57, 8'h83);
      send_request(FUNC_DIV, 8'h00, 8'h00);
      send_request(FUNC_DIV, 8'hFF, 8'hFF);
      send_request(FUNC_DIV, 8'h53, 8'hCA);
      drain();

      // random: sender gaps at 19 %, then 86 %, then back to back
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 19 : (phase == 1) ? 86 : 0;
         repeat (PHASE_ITEMS) begin
            send_request(2'($urandom_range(0, 3)), pick_operand(), pick_operand());
         end
         drain();
      end

      if (sb.pending() != 0) begin
         $error("field_result: %0d expected responses never arrived", sb.pending());
         sb.errors++;
      end
      $display("covered %0d add, %0d xtime, %0d multiply, %0d divide requests;",
               sb.op_count[FUNC_ADD], sb.op_count[FUNC_XTIME],
               sb.op_count[FUNC_MUL], sb.op_count[FUNC_DIV]);
      $display("%0d responses checked with %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("gf256_arithmetic_unit_core_test passed");
      end else begin
         $display("gf256_arithmetic_unit_core_test failed");
      end
      $finish;
   end

endmodule
